@@ sv/bfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Buffer frame replacement package
// Shared types and status codes for the frame table.
// ----------------------------------------------------------------------------
package bfr_pkg;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_t;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_REPLACED  = 3'd2;
  localparam logic [2:0] ST_NO_VICTIM = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;
  localparam logic [2:0] ST_REFUSED   = 3'd5;

  // One queued word between the front and the back.
  typedef struct packed {
    cmd_t        command;
    logic [15:0] page_number;
    logic [2:0]  frame_number;
    logic        pin_wanted;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_APPLY
  } bk_state_t;

endpackage

@@ sv/bfr_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Accepts input words and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bfr_front import bfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_page_number,
  input  logic [2:0]  in_frame_number,
  input  logic        in_pin_wanted,
  output logic        q_valid,
  input  logic        q_pop,
  output item_t       q_item
);

  item_t      mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{command: cmd_t'(in_command), page_number: in_page_number,
                       frame_number: in_frame_number, pin_wanted: in_pin_wanted};
    end
  end

endmodule

@@ sv/bfr_back.sv @@
// ----------------------------------------------------------------------------
// Back end
// Frame table: lookup, victim selection, clock sweep and result register.
// ----------------------------------------------------------------------------
module bfr_back import bfr_pkg::*; #(
  parameter int NUM_FRAMES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        use_lru,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_frame_used,
  output logic [15:0] out_evicted_page,
  output logic        out_evicted_dirty,
  output logic [7:0]  out_use_count
);

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [FW-1:0] LAST = FW'(NUM_FRAMES - 1);

  logic [15:0]   page_r   [NUM_FRAMES];
  logic          dirty_r  [NUM_FRAMES];
  logic          pinned_r [NUM_FRAMES];
  logic [7:0]    uses_r   [NUM_FRAMES];
  logic          ref_r    [NUM_FRAMES];
  logic [FW-1:0] rec_r    [NUM_FRAMES];
  logic [FW-1:0] hand_r, hand_nxt;
  logic [FW:0]   steps_r, steps_nxt;

  bk_state_t state_r, state_nxt;

  // Lookup results, computed from the current table.
  logic          hit, empty_found, lru_found;
  logic [FW-1:0] hit_f, empty_f, lru_f;
  logic          hand_ok;

  always_comb begin
    hit = 1'b0; hit_f = '0; empty_found = 1'b0; empty_f = '0;
    lru_found = 1'b0; lru_f = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (page_r[i] == q_item.page_number) begin
        hit = 1'b1; hit_f = FW'(i);
      end
      if (page_r[i] == 16'd0) begin
        empty_found = 1'b1; empty_f = FW'(i);
      end
    end
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!pinned_r[i] && uses_r[i] == 8'd0 &&
          (!lru_found || rec_r[i] > rec_r[lru_f])) begin
        lru_found = 1'b1; lru_f = FW'(i);
      end
    end
    hand_ok = !ref_r[hand_r] && !pinned_r[hand_r] && uses_r[hand_r] == 8'd0;
  end

  // Decide the action for the current word in the apply step.
  logic          act_frame;   // frame is served / acted upon
  logic          load;        // frame gets a new page
  logic [FW-1:0] f_sel;
  logic [2:0]    st;
  logic          frame_ok;

  logic hand_ok_at_stop_r, hand_ok_at_stop_nxt;
  logic [FW-1:0] victim_r, victim_nxt;

  assign frame_ok = ({5'd0, q_item.frame_number} < 8'(NUM_FRAMES));

  always_comb begin
    act_frame = 1'b0; load = 1'b0; f_sel = '0; st = ST_REFUSED;
    case (q_item.command)
      CMD_REQUEST: begin
        if (q_item.page_number != 16'd0) begin
          if (hit) begin
            st = ST_HIT; f_sel = hit_f; act_frame = 1'b1;
          end else if (empty_found) begin
            st = ST_FILLED; f_sel = empty_f; act_frame = 1'b1; load = 1'b1;
          end else if (use_lru ? lru_found : hand_ok_at_stop_r) begin
            st = ST_REPLACED; f_sel = use_lru ? lru_f : victim_r;
            act_frame = 1'b1; load = 1'b1;
          end else begin
            st = ST_NO_VICTIM;
          end
        end
      end
      CMD_WRITE: begin
        if (q_item.page_number != 16'd0 && hit) begin
          st = ST_DONE; f_sel = hit_f;
        end
      end
      CMD_RELEASE: begin
        f_sel = FW'(q_item.frame_number);
        if (frame_ok && uses_r[f_sel] != 8'd0) st = ST_DONE;
      end
      CMD_UNPIN: begin
        f_sel = FW'(q_item.frame_number);
        if (frame_ok && pinned_r[f_sel]) st = ST_DONE;
      end
      default: st = ST_REFUSED;
    endcase
  end

  // A clock sweep is needed only for a clock-mode miss with no empty frame.
  logic need_sweep;
  assign need_sweep = q_item.command == CMD_REQUEST && q_item.page_number != 16'd0 &&
                      !hit && !empty_found && !use_lru;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (q_valid) state_nxt = need_sweep ? BK_SWEEP : BK_APPLY;
      BK_SWEEP: if (hand_ok || steps_r == (FW+1)'(NUM_FRAMES - 1)) state_nxt = BK_APPLY;
      BK_APPLY: if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Sweep bookkeeping.
  always_comb begin
    hand_nxt = hand_r; steps_nxt = steps_r;
    hand_ok_at_stop_nxt = hand_ok_at_stop_r; victim_nxt = victim_r;
    case (state_r)
      BK_IDLE: begin
        steps_nxt = '0; hand_ok_at_stop_nxt = 1'b0;
      end
      BK_SWEEP: begin
        hand_nxt  = (hand_r == LAST) ? '0 : hand_r + 1'b1;
        steps_nxt = steps_r + 1'b1;
        if (hand_ok) begin
          hand_ok_at_stop_nxt = 1'b1; victim_nxt = hand_r;
        end
      end
      default: ;
    endcase
  end

  // Outputs of the control.
  always_comb begin
    q_pop = (state_r == BK_APPLY) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      hand_r <= '0;
      steps_r <= '0;
      hand_ok_at_stop_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hand_r <= hand_nxt;
      steps_r <= steps_nxt;
      hand_ok_at_stop_r <= hand_ok_at_stop_nxt;
      if (q_pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) victim_r <= victim_nxt;

  // Table update.
  logic [7:0] new_uses;
  always_comb begin
    new_uses = load ? 8'd0 : uses_r[f_sel];
    if (act_frame && new_uses != 8'hFF) new_uses = new_uses + 8'd1;
    if (q_item.command == CMD_RELEASE && st == ST_DONE) new_uses = new_uses - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        page_r[i] <= '0; dirty_r[i] <= 1'b0; pinned_r[i] <= 1'b0;
        uses_r[i] <= '0; ref_r[i] <= 1'b0; rec_r[i] <= '0;
      end
    end else if (state_r == BK_SWEEP && !hand_ok) begin
      ref_r[hand_r] <= 1'b0;
    end else if (q_pop) begin
      if (load) begin
        page_r[f_sel]  <= q_item.page_number;
        dirty_r[f_sel] <= 1'b0;
      end
      if (act_frame) begin
        pinned_r[f_sel] <= q_item.pin_wanted | (pinned_r[f_sel] & ~load);
        uses_r[f_sel]   <= new_uses;
        if (use_lru) begin
          // A loaded frame starts unreferenced; the rank moves to most recent.
          if (load) ref_r[f_sel] <= 1'b0;
          for (int i = 0; i < NUM_FRAMES; i++) begin
            if (FW'(i) == f_sel) rec_r[i] <= '0;
            else if (rec_r[i] <= rec_r[f_sel] && rec_r[i] < LAST)
              rec_r[i] <= rec_r[i] + 1'b1;
          end
        end else begin
          ref_r[f_sel] <= 1'b1;
        end
      end else if (st == ST_DONE) begin
        case (q_item.command)
          CMD_WRITE:   dirty_r[f_sel] <= 1'b1;
          CMD_RELEASE: uses_r[f_sel] <= new_uses;
          CMD_UNPIN:   pinned_r[f_sel] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_status        <= st;
      out_frame_used    <= (act_frame || st == ST_DONE) ? 3'(f_sel) : 3'd0;
      out_evicted_page  <= (st == ST_REPLACED) ? page_r[f_sel] : 16'd0;
      out_evicted_dirty <= (st == ST_REPLACED) ? dirty_r[f_sel] : 1'b0;
      out_use_count     <= (act_frame || st == ST_DONE) ?
                           ((act_frame || q_item.command == CMD_RELEASE) ?
                            new_uses : uses_r[f_sel]) : 8'd0;
    end
  end

endmodule

@@ sv/buffer_frame_replacement_top.sv @@
// ----------------------------------------------------------------------------
// Buffer frame replacement top
// Buffer-pool frame table with LRU or clock replacement.
//
//   channel   direction  fields
//   in_       input      command, page_number, frame_number, pin_wanted
//   out_      output     status, frame_used, evicted_page, evicted_dirty, use_count
//   cfg_      input      data (use_lru)
//
// A word passes through the back end's idle and apply steps, with a sweep step
// between them on a clock-mode miss, in which the hand passes up to NUM_FRAMES frames.
// The two-entry queue lets the front accept while the back works.
// Reset is synchronous and clears the whole frame table at once.
// A stalled result holds the back end in its apply step.
// ----------------------------------------------------------------------------
module buffer_frame_replacement_top import bfr_pkg::*; #(
  parameter int NUM_FRAMES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_page_number,
  input  logic [2:0]  in_frame_number,
  input  logic        in_pin_wanted,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_frame_used,
  output logic [15:0] out_evicted_page,
  output logic        out_evicted_dirty,
  output logic [7:0]  out_use_count
);

  logic  use_lru_r;
  logic  q_valid, q_pop;
  item_t q_item;

  // Policy register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) use_lru_r <= 1'b0;
    else if (cfg_valid) use_lru_r <= cfg_data;
  end

  bfr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_page_number,
    .in_frame_number, .in_pin_wanted, .q_valid, .q_pop, .q_item
  );

  bfr_back #(.NUM_FRAMES(NUM_FRAMES)) u_back (
    .clk, .rst_n, .use_lru(use_lru_r), .q_valid, .q_pop, .q_item,
    .out_valid, .out_ready, .out_status, .out_frame_used, .out_evicted_page,
    .out_evicted_dirty, .out_use_count
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer frame replacement testbench
// Drives request, write, release and unpin words into the frame table under
// both replacement policies, predicts every result with an internal model of
// the table, and compares each result word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bfr_pkg::*;

  localparam int NF = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int MAX_ROWS = 32;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  frame_used;
    logic [15:0] evicted_page;
    logic        evicted_dirty;
    logic [7:0]  use_count;
  } result_t;

  // Directed row: stimulus plus an optional typed-in expectation.
  typedef struct {
    cmd_t        command;
    logic [15:0] page;
    logic [2:0]  frame;
    logic        pin;
    bit          fixed;
    result_t     res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = '0;
  logic [15:0] in_page_number = '0;
  logic [2:0]  in_frame_number = '0;
  logic        in_pin_wanted = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_frame_used;
  logic [15:0] out_evicted_page;
  logic        out_evicted_dirty;
  logic [7:0]  out_use_count;

  // Predicted copy of the frame table.
  logic        lru_mode;
  logic [15:0] pg [NF];
  logic        dirty [NF];
  logic        pinned [NF];
  logic [7:0]  uses [NF];
  logic        refd [NF];
  logic [2:0]  rank [NF];
  logic [2:0]  hand;

  result_t expected_results[$];
  int      failures = 0;
  int      idle_cycles = 0;
  bit      hold_off = 1'b0;
  bit      long_stall_req = 1'b0;

  // Directed table and the typed-in expectation travelling with each word.
  row_t    rows [MAX_ROWS];
  int      n_rows = 0;
  bit      row_fixed = 1'b0;
  result_t row_res = '0;

  buffer_frame_replacement_top #(.NUM_FRAMES(NF)) u_top (.*);

  always #6 clk = ~clk;

  function automatic int find_frame(logic [15:0] p);
    for (int i = 0; i < NF; i++) if (pg[i] == p) return i;
    return -1;
  endfunction

  function automatic void touch_rank(int f);
    logic [2:0] old;
    old = rank[f];
    for (int i = 0; i < NF; i++)
      if (i != f && rank[i] <= old && rank[i] < NF - 1) rank[i]++;
    rank[f] = '0;
  endfunction

  function automatic int pick_victim();
    int best;
    best = -1;
    if (lru_mode) begin
      for (int i = 0; i < NF; i++) begin
        if (pinned[i] || uses[i] != 8'd0) continue;
        if (best < 0 || rank[i] > rank[best]) best = i;
      end
      return best;
    end
    for (int n = 0; n < NF; n++) begin
      int h;
      h = int'(hand);
      hand = hand + 3'd1;
      if (!refd[h] && !pinned[h] && uses[h] == 8'd0) return h;
      refd[h] = 1'b0;
    end
    return -1;
  endfunction

  function automatic void load_page(int f, logic [15:0] p);
    pg[f] = p;
    dirty[f] = 1'b0;
    pinned[f] = 1'b0;
    uses[f] = 8'd0;
    refd[f] = 1'b0;
  endfunction

  function automatic result_t mk_res(logic [2:0] st, logic [2:0] fr, logic [7:0] cnt);
    result_t r;
    r = '0;
    r.status = st;
    r.frame_used = fr;
    r.use_count = cnt;
    return r;
  endfunction

  // Applies one word to the predicted table and returns its result.
  function automatic result_t predict_frame_step(cmd_t c, logic [15:0] p, logic [2:0] fn,
                                                 logic pin);
    result_t r;
    int f;
    r = '0;
    r.status = ST_REFUSED;
    case (c)
      CMD_REQUEST: begin
        if (p != 16'd0) begin
          f = find_frame(p);
          if (f >= 0) begin
            r.status = ST_HIT;
          end else begin
            f = find_frame(16'd0);
            if (f >= 0) begin
              r.status = ST_FILLED;
              load_page(f, p);
            end else begin
              f = pick_victim();
              if (f >= 0) begin
                r.status = ST_REPLACED;
                r.evicted_page = pg[f];
                r.evicted_dirty = dirty[f];
                load_page(f, p);
              end else begin
                r.status = ST_NO_VICTIM;
              end
            end
          end
          if (f >= 0) begin
            if (pin) pinned[f] = 1'b1;
            if (uses[f] != 8'd255) uses[f]++;
            if (lru_mode) touch_rank(f);
            else refd[f] = 1'b1;
            r.frame_used = 3'(f);
            r.use_count = uses[f];
          end
        end
      end
      CMD_WRITE: begin
        if (p != 16'd0) begin
          f = find_frame(p);
          if (f >= 0) begin
            dirty[f] = 1'b1;
            r.status = ST_DONE;
            r.frame_used = 3'(f);
            r.use_count = uses[f];
          end
        end
      end
      default: begin
        if (int'(fn) < NF) begin
          if (c == CMD_RELEASE && uses[fn] != 8'd0) begin
            uses[fn]--;
            r.status = ST_DONE;
          end else if (c == CMD_UNPIN && pinned[fn]) begin
            pinned[fn] = 1'b0;
            r.status = ST_DONE;
          end
          if (r.status == ST_DONE) begin
            r.frame_used = fn;
            r.use_count = uses[fn];
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic add_row(cmd_t c, logic [15:0] p, logic [2:0] fn, logic pin, bit fx,
                         result_t res);
    rows[n_rows] = '{c, p, fn, pin, fx, res};
    n_rows++;
  endtask

  // Offers one word and waits for it to be taken.
  task automatic send_word(cmd_t c, logic [15:0] p, logic [2:0] fn, logic pin);
    in_valid <= 1'b1;
    in_command <= c;
    in_page_number <= p;
    in_frame_number <= fn;
    in_pin_wanted <= pin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : ($urandom_range(0, 19) == 0 ?
        $urandom_range(10, 40) : $urandom_range(1, 3));
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Waits until the last accepted word is recorded, then for every result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_policy(logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lru_mode = v;
  endtask

  task automatic send_random(int pool_hi);
    int k;
    cmd_t c;
    logic [15:0] p;
    k = $urandom_range(0, 99);
    c = k < 55 ? CMD_REQUEST : k < 70 ? CMD_WRITE : k < 88 ? CMD_RELEASE : CMD_UNPIN;
    p = 16'($urandom_range(1, pool_hi));
    if ($urandom_range(0, 40) == 0) p = 16'd0;
    if ($urandom_range(0, 30) == 0) p = 16'($urandom);
    send_word(c, p, 3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
    send_gap();
  endtask

  // Record the expectation on the accepting edge.
  always @(posedge clk) begin
    result_t pred;
    if (rst_n && in_valid && in_ready) begin
      pred = predict_frame_step(cmd_t'(in_command), in_page_number, in_frame_number,
                                in_pin_wanted);
      if (row_fixed && pred !== row_res) begin
        $display("%0t: table row expected %h predicted %h", $time, row_res, pred);
        failures++;
      end
      expected_results.insert(expected_results.size(), pred);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_status, out_frame_used, out_evicted_page, out_evicted_dirty, out_use_count};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.frame_used !== want.frame_used)
          $display("%0t: frame expected %0d actual %0d", $time, want.frame_used,
                   got.frame_used);
        if (got.evicted_page !== want.evicted_page)
          $display("%0t: evicted page expected %h actual %h", $time, want.evicted_page,
                   got.evicted_page);
        if (got.evicted_dirty !== want.evicted_dirty)
          $display("%0t: evicted dirty expected %b actual %b", $time, want.evicted_dirty,
                   got.evicted_dirty);
        if (got.use_count !== want.use_count)
          $display("%0t: use count expected %0d actual %0d", $time, want.use_count,
                   got.use_count);
        if (got !== want) failures++;
      end
    end
  end

  // Receiver: random stalls and random hold-offs, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) < 7) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
        long_stall_req = 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        hold_off = 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        hold_off = 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL buffer_frame_replacement_top");
      $finish;
    end
  end

  initial begin
    lru_mode = 1'b0;
    hand = '0;
    for (int i = 0; i < NF; i++) begin
      pg[i] = '0; dirty[i] = 1'b0; pinned[i] = 1'b0; uses[i] = '0; refd[i] = 1'b0;
      rank[i] = '0;
    end

    // Directed table: extremes, every command and the refusal cases.
    add_row(CMD_REQUEST, 16'd0,    3'd0, 1'b0, 1'b1, mk_res(ST_REFUSED, 3'd0, 8'd0));
    add_row(CMD_WRITE,   16'd0,    3'd0, 1'b0, 1'b1, mk_res(ST_REFUSED, 3'd0, 8'd0));
    add_row(CMD_WRITE,   16'd5,    3'd0, 1'b0, 1'b1, mk_res(ST_REFUSED, 3'd0, 8'd0));
    add_row(CMD_RELEASE, 16'd0,    3'd7, 1'b0, 1'b1, mk_res(ST_REFUSED, 3'd0, 8'd0));
    add_row(CMD_UNPIN,   16'd0,    3'd0, 1'b0, 1'b1, mk_res(ST_REFUSED, 3'd0, 8'd0));
    add_row(CMD_REQUEST, 16'hFFFF, 3'd0, 1'b1, 1'b1, mk_res(ST_FILLED, 3'd0, 8'd1));
    add_row(CMD_REQUEST, 16'hFFFF, 3'd7, 1'b0, 1'b1, mk_res(ST_HIT, 3'd0, 8'd2));
    add_row(CMD_WRITE,   16'hFFFF, 3'd0, 1'b0, 1'b1, mk_res(ST_DONE, 3'd0, 8'd2));
    add_row(CMD_UNPIN,   16'h0,    3'd0, 1'b0, 1'b1, mk_res(ST_DONE, 3'd0, 8'd2));
    add_row(CMD_UNPIN,   16'h0,    3'd0, 1'b0, 1'b1, mk_res(ST_REFUSED, 3'd0, 8'd0));
    for (int i = 1; i < NF; i++)
      add_row(CMD_REQUEST, 16'(i), 3'd0, 1'b0, 1'b0, '0);
    add_row(CMD_RELEASE, 16'h0, 3'd0, 1'b0, 1'b1, mk_res(ST_DONE, 3'd0, 8'd1));
    add_row(CMD_RELEASE, 16'h0, 3'd0, 1'b0, 1'b1, mk_res(ST_DONE, 3'd0, 8'd0));
    add_row(CMD_RELEASE, 16'h0, 3'd0, 1'b0, 1'b1, mk_res(ST_REFUSED, 3'd0, 8'd0));
    // Table full and frame 0 still referenced: a full sweep finds no victim.
    add_row(CMD_REQUEST, 16'h1234, 3'd0, 1'b0, 1'b0, '0);
    // The sweep cleared frame 0's reference bit, so it is taken now.
    add_row(CMD_REQUEST, 16'h4321, 3'd0, 1'b0, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < n_rows; i++) begin
      row_fixed <= rows[i].fixed;
      row_res <= rows[i].res;
      send_word(rows[i].command, rows[i].page, rows[i].frame, rows[i].pin);
      send_gap();
    end
    row_fixed <= 1'b0;
    drain();

    // Random phases alternating policy; small page pools force eviction.
    for (int ph = 0; ph < 6; ph++) begin
      write_policy(ph % 2 == 0);
      if (ph == 2) long_stall_req = 1'b1;
      for (int n = 0; n < 190; n++) begin
        send_random(ph < 4 ? 14 : 40);
        if (n == 95) drain();
      end
      drain();
    end
    write_policy(1'b0);

    if (failures == 0) begin
      $display("PASS buffer_frame_replacement_top");
    end else begin
      $display("FAIL buffer_frame_replacement_top");
    end
    $finish;
  end

endmodule

@@ buffer_frame_replacement_top.f @@
sv/bfr_pkg.sv
sv/bfr_front.sv
sv/bfr_back.sv
sv/buffer_frame_replacement_top.sv
tb/testbench.sv
